// ===== design/glhd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the group load hysteresis detector
package glhd_pkg;

    localparam int GLHD_TIME_WIDTH = 64;

    localparam int PCT_W   = 7;
    localparam int CNT4_W  = 4;
    localparam int CNT8_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_PCT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_NEEDED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_EVRY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_AFT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIM  = 3'd7;

    // action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_HIGH    = 2'd2;

    // multiplier applied to the busy delta
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    typedef struct packed {
        logic [PCT_W-1:0]  high_percent;
        logic [PCT_W-1:0]  normal_percent;
        logic [CNT4_W-1:0] window_ticks;
        logic [CNT4_W-1:0] high_ticks_needed;
        logic [CNT4_W-1:0] release_every;
        logic [CNT4_W-1:0] sustain_after;
        logic [CNT8_W-1:0] sustain_limit;
        logic [CNT8_W-1:0] release_limit;
    } t_glhd_cfg;

    typedef struct packed {
        logic       window_end;
        logic [1:0] action;
        logic       status_high;
        logic       tick_high;
        logic       tick_normal;
    } t_glhd_result;

    function automatic logic [CNT4_W-1:0] sat_inc4(input logic [CNT4_W-1:0] v);
        return (v == {CNT4_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT8_W-1:0] sat_inc8(input logic [CNT8_W-1:0] v);
        return (v == {CNT8_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== design/glhd_tick_classify.sv =====
`timescale 1ns / 1ps
// classifies one tick as high load, normal load or neither from its time deltas
module glhd_tick_classify #(
    parameter int TIME_WIDTH = glhd_pkg::GLHD_TIME_WIDTH
) (
    input  logic [TIME_WIDTH-1:0]      i_delta_total,
    input  logic [TIME_WIDTH-1:0]      i_delta_busy,
    input  logic [glhd_pkg::PCT_W-1:0] i_high_percent,
    input  logic [glhd_pkg::PCT_W-1:0] i_normal_percent,
    output logic                       o_tick_high,
    output logic                       o_tick_normal
);
    import glhd_pkg::*;

    localparam int PROD_W = TIME_WIDTH + PCT_W;

    logic [PROD_W-1:0] busy_scaled;
    logic [PROD_W-1:0] high_bound;
    logic [PROD_W-1:0] normal_bound;
    logic              total_nonzero;

    // exact products, no wrap
    assign busy_scaled   = {{PCT_W{1'b0}}, i_delta_busy} * {{TIME_WIDTH{1'b0}}, PCT_SCALE};
    assign high_bound    = {{PCT_W{1'b0}}, i_delta_total} *
                           {{TIME_WIDTH{1'b0}}, i_high_percent};
    assign normal_bound  = {{PCT_W{1'b0}}, i_delta_total} *
                           {{TIME_WIDTH{1'b0}}, i_normal_percent};
    assign total_nonzero = |i_delta_total;

    assign o_tick_high   = total_nonzero && (busy_scaled >= high_bound);
    assign o_tick_normal = total_nonzero && (busy_scaled < normal_bound);

endmodule

// ===== design/glhd_window_ctrl.sv =====
`timescale 1ns / 1ps
// window and cycle counters with the high / low status decision
module glhd_window_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_commit,
    input  logic                    i_tick_high,
    input  logic                    i_tick_normal,
    input  glhd_pkg::t_glhd_cfg     i_cfg,
    output glhd_pkg::t_glhd_result  o_result
);
    import glhd_pkg::*;

    logic [CNT4_W-1:0] r_win_pos,   n_win_pos;
    logic [CNT4_W-1:0] r_win_high,  n_win_high;
    logic [CNT4_W-1:0] r_win_norm,  n_win_norm;
    logic [CNT8_W-1:0] r_cyc_high,  n_cyc_high;
    logic [CNT8_W-1:0] r_cyc_norm,  n_cyc_norm;
    logic [CNT8_W-1:0] r_win_count, n_win_count;
    logic [CNT4_W-1:0] r_rel_phase, n_rel_phase;
    logic              r_is_high,   n_is_high;

    logic [CNT4_W-1:0] pos_inc;
    logic              done;
    logic              clear_cycle;
    logic [1:0]        action;
    logic              wend;

    always_comb begin
        n_win_high  = i_tick_high   ? sat_inc4(r_win_high) : r_win_high;
        n_cyc_high  = i_tick_high   ? sat_inc8(r_cyc_high) : r_cyc_high;
        n_win_norm  = i_tick_normal ? sat_inc4(r_win_norm) : r_win_norm;
        n_cyc_norm  = i_tick_normal ? sat_inc8(r_cyc_norm) : r_cyc_norm;
        n_win_count = r_win_count;
        n_rel_phase = r_rel_phase;
        n_is_high   = r_is_high;
        pos_inc     = sat_inc4(r_win_pos);
        n_win_pos   = pos_inc;
        done        = 1'b0;
        clear_cycle = 1'b0;
        action      = ACT_NONE;
        wend        = 1'b0;

        if (pos_inc >= i_cfg.window_ticks) begin
            wend        = 1'b1;
            n_win_count = sat_inc8(r_win_count);
            // entry to high status
            if (n_win_high >= i_cfg.high_ticks_needed && !r_is_high) begin
                n_is_high   = 1'b1;
                action      = ACT_HIGH;
                clear_cycle = 1'b1;
                done        = 1'b1;
            end else begin
                n_rel_phase = sat_inc4(r_rel_phase);
                if (n_rel_phase >= i_cfg.release_every) begin
                    n_rel_phase = '0;
                    if (r_is_high && n_cyc_norm > i_cfg.release_limit) begin
                        n_is_high   = 1'b0;
                        action      = ACT_RELEASE;
                        clear_cycle = 1'b1;
                        done        = 1'b1;
                    end
                end
            end
            // sustained high check
            if (!done && n_win_count >= {{(CNT8_W-CNT4_W){1'b0}}, i_cfg.sustain_after}) begin
                if (r_is_high && n_cyc_high > i_cfg.sustain_limit) begin
                    action = ACT_HIGH;
                end
                clear_cycle = 1'b1;
            end
            n_win_pos  = '0;
            n_win_high = '0;
            n_win_norm = '0;
        end

        if (clear_cycle) begin
            n_cyc_high  = '0;
            n_cyc_norm  = '0;
            n_win_count = '0;
            n_rel_phase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_pos   <= '0;
            r_win_high  <= '0;
            r_win_norm  <= '0;
            r_cyc_high  <= '0;
            r_cyc_norm  <= '0;
            r_win_count <= '0;
            r_rel_phase <= '0;
            r_is_high   <= 1'b0;
        end else if (i_commit) begin
            r_win_pos   <= n_win_pos;
            r_win_high  <= n_win_high;
            r_win_norm  <= n_win_norm;
            r_cyc_high  <= n_cyc_high;
            r_cyc_norm  <= n_cyc_norm;
            r_win_count <= n_win_count;
            r_rel_phase <= n_rel_phase;
            r_is_high   <= n_is_high;
        end
    end

    assign o_result.window_end  = wend;
    assign o_result.action      = action;
    assign o_result.status_high = n_is_high;
    assign o_result.tick_high   = i_tick_high;
    assign o_result.tick_normal = i_tick_normal;

endmodule

// ===== design/group_load_hysteresis_detector.sv =====
`timescale 1ns / 1ps
// top level of the group load hysteresis detector
//
// usage
// - input channel: i_in_valid / o_in_stall carry one sample word, the
//   cumulative total and busy time of a cpu group; a word is taken at a
//   rising edge with i_in_valid high and o_in_stall low
// - output channel: o_out_valid / i_out_stall carry one result word per
//   sample: window_end, action, status_high, tick_high, tick_normal
// - config channel: i_cfg_valid / o_cfg_ready with a 3-bit register index
//   and 8-bit data; ready is always high, write only while the block is idle
// - a taken sample passes the delta register, then the result register
// - throughput: one sample per cycle unless the receiver stalls; the delta
//   subtract happens at the input register, the two multiply-compares and
//   the window decision fill the single stage in front of the result register
// - when the receiver stalls, the result register holds and the sample stage
//   holds behind it; o_in_stall rises only when both are full
// - reset clears the previous sample, all counters, status (low) and loads the
//   default thresholds; no clearing pass, the block is ready on the next cycle
module group_load_hysteresis_detector #(
    parameter int TIME_WIDTH = glhd_pkg::GLHD_TIME_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [TIME_WIDTH-1:0]           i_group_total_time,
    input  logic [TIME_WIDTH-1:0]           i_group_busy_time,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_window_end,
    output logic [1:0]                      o_action,
    output logic                            o_status_high,
    output logic                            o_tick_high,
    output logic                            o_tick_normal,
    // register write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [glhd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [glhd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import glhd_pkg::*;

    // configuration registers
    t_glhd_cfg r_cfg;

    // previous sample and the delta stage
    logic [TIME_WIDTH-1:0] r_prev_total;
    logic [TIME_WIDTH-1:0] r_prev_busy;
    logic [TIME_WIDTH-1:0] r_delta_total;
    logic [TIME_WIDTH-1:0] r_delta_busy;
    logic                  r_s1_valid;

    // result register
    t_glhd_result r_out;
    logic         r_out_valid;

    logic         out_free;
    logic         s1_move;
    logic         in_take;
    logic         tick_high;
    logic         tick_normal;
    t_glhd_result result;

    // handshake: the result register frees when empty or taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_percent      <= 7'd95;
            r_cfg.normal_percent    <= 7'd60;
            r_cfg.window_ticks      <= 4'd5;
            r_cfg.high_ticks_needed <= 4'd4;
            r_cfg.release_every     <= 4'd3;
            r_cfg.sustain_after     <= 4'd6;
            r_cfg.sustain_limit     <= 8'd24;
            r_cfg.release_limit     <= 8'd12;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HIGH_PCT:     r_cfg.high_percent      <= i_cfg_data[PCT_W-1:0];
                REG_NORMAL_PCT:   r_cfg.normal_percent    <= i_cfg_data[PCT_W-1:0];
                REG_WINDOW_TICKS: r_cfg.window_ticks      <= i_cfg_data[CNT4_W-1:0];
                REG_HIGH_NEEDED:  r_cfg.high_ticks_needed <= i_cfg_data[CNT4_W-1:0];
                REG_RELEASE_EVRY: r_cfg.release_every     <= i_cfg_data[CNT4_W-1:0];
                REG_SUSTAIN_AFT:  r_cfg.sustain_after     <= i_cfg_data[CNT4_W-1:0];
                REG_SUSTAIN_LIM:  r_cfg.sustain_limit     <= i_cfg_data[CNT8_W-1:0];
                REG_RELEASE_LIM:  r_cfg.release_limit     <= i_cfg_data[CNT8_W-1:0];
            endcase
        end
    end

    // previous sample, wraps naturally mod 2^TIME_WIDTH
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_total <= '0;
            r_prev_busy  <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (in_take) begin
                r_prev_total <= i_group_total_time;
                r_prev_busy  <= i_group_busy_time;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // delta payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_delta_total <= i_group_total_time - r_prev_total;
            r_delta_busy  <= i_group_busy_time - r_prev_busy;
        end
    end

    glhd_tick_classify #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classify (
        .i_delta_total    (r_delta_total),
        .i_delta_busy     (r_delta_busy),
        .i_high_percent   (r_cfg.high_percent),
        .i_normal_percent (r_cfg.normal_percent),
        .o_tick_high      (tick_high),
        .o_tick_normal    (tick_normal)
    );

    // counters advance only when the word moves into the result register
    glhd_window_ctrl u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (s1_move),
        .i_tick_high   (tick_high),
        .i_tick_normal (tick_normal),
        .i_cfg         (r_cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_window_end  = r_out.window_end;
    assign o_action      = r_out.action;
    assign o_status_high = r_out.status_high;
    assign o_tick_high   = r_out.tick_high;
    assign o_tick_normal = r_out.tick_normal;

    // an action only ever comes with a window close
    a_action_needs_wend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_NONE) |-> o_window_end)
        else $error("action reported without window end");

    // the action agrees with the status it leaves behind
    a_action_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_HIGH) |-> o_status_high)
        else $error("high action with low status");

    a_release_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_RELEASE) |-> !o_status_high)
        else $error("release action with high status");

    // nothing leaves the block in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
